// ----- rtl/pcu8_pkg.sv -----
// ----------------------------------------------------------------------------
// pcu8_pkg
// shared types and constants for the path component utf-8 checker
// ----------------------------------------------------------------------------
package pcu8_pkg;

  localparam int unsigned LenWidth   = 12;
  localparam int unsigned CountWidth = LenWidth + 1;
  localparam int unsigned CpWidth    = 21;
  localparam int unsigned MinWidth   = 17;

  localparam logic [LenWidth-1:0] MaxLenReset = 12'd255;

  localparam logic [CpWidth-1:0]  MaxCodePoint  = 21'h10ffff;
  localparam logic [CpWidth-1:0]  SurrogateLow  = 21'h00d800;
  localparam logic [CpWidth-1:0]  SurrogateHigh = 21'h00dfff;
  localparam logic [MinWidth-1:0] MinFour       = 17'h10000;
  localparam logic [MinWidth-1:0] MinThree      = 17'h00800;
  localparam logic [MinWidth-1:0] MinTwo        = 17'h00080;

  localparam logic [7:0] DelByte   = 8'h7f;
  localparam logic [7:0] SpaceByte = 8'h20;
  localparam logic [7:0] DotByte   = 8'h2e;
  localparam logic [7:0] SlashByte = 8'h2f;
  localparam logic [7:0] BslashByte = 8'h5c;
  localparam logic [7:0] ContMask  = 8'hc0;
  localparam logic [7:0] ContTag   = 8'h80;
  localparam logic [7:0] ContBits  = 8'h3f;

  typedef enum logic [1:0] {
    DOT_NONE  = 2'd0,
    DOT_ONE   = 2'd1,
    DOT_TWO   = 2'd2,
    DOT_OTHER = 2'd3
  } dot_t;

  typedef enum logic [2:0] {
    REASON_OK        = 3'd0,
    REASON_LENGTH    = 3'd1,
    REASON_DOT       = 3'd2,
    REASON_FORBIDDEN = 3'd3,
    REASON_UTF8      = 3'd4
  } reason_t;

endpackage

// ----- rtl/path_component_utf8_checker.sv -----
// ----------------------------------------------------------------------------
// path_component_utf8_checker
// the verdict is registered in the result register when the input register passes on the last byte
// throughput: one byte per cycle while in_stall is low, set by the single-pass decode stage
// input register, one stage of decode and length logic, result register
// reset: synchronous, clears all component state, limit returns to 255
// ----------------------------------------------------------------------------
module path_component_utf8_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [11:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        name_ok,
  output logic [2:0]  fail_reason
);

  logic [pcu8_pkg::LenWidth-1:0]   max_name_length;
  logic                            s1_valid;
  logic [7:0]                      s1_byte;
  logic                            s1_has;
  logic                            s1_last;
  logic [pcu8_pkg::CountWidth-1:0] byte_count;
  logic [1:0]                      pending;
  logic [pcu8_pkg::CpWidth-1:0]    code_point;
  logic [pcu8_pkg::MinWidth-1:0]   seq_min;
  pcu8_pkg::dot_t                  dot_prefix;
  logic                            forbidden_seen;
  logic                            enc_error;
  pcu8_pkg::reason_t               reason;

  logic [pcu8_pkg::CountWidth-1:0] byte_count_next;
  logic [1:0]                      pending_next;
  logic [pcu8_pkg::CpWidth-1:0]    code_point_next;
  logic [pcu8_pkg::MinWidth-1:0]   seq_min_next;
  pcu8_pkg::dot_t                  dot_prefix_next;
  logic                            forbidden_next;
  logic                            enc_error_next;
  pcu8_pkg::reason_t               reason_next;

  logic out_free;
  logic s1_go;
  logic s1_fire;
  logic in_accept;

  assign out_free  = !out_valid || !out_stall;
  assign s1_go     = !s1_last || out_free;
  assign s1_fire   = s1_valid && s1_go;
  assign in_stall  = s1_valid && !s1_go;
  assign in_accept = in_valid && !in_stall;

  assign name_ok     = (reason == pcu8_pkg::REASON_OK);
  assign fail_reason = reason;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_name_length <= pcu8_pkg::MaxLenReset;
    end else if (cfg_write_en) begin
      max_name_length <= cfg_write_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte <= data_byte;
      s1_has  <= has_byte;
      s1_last <= last_byte;
    end
  end

  // per-byte update and verdict
  always_comb begin
    logic [pcu8_pkg::CountWidth-1:0] limit;
    logic [pcu8_pkg::CpWidth-1:0]    cp_shift;
    byte_count_next = byte_count;
    pending_next    = pending;
    code_point_next = code_point;
    seq_min_next    = seq_min;
    dot_prefix_next = dot_prefix;
    forbidden_next  = forbidden_seen;
    enc_error_next  = enc_error;
    reason_next     = pcu8_pkg::REASON_OK;
    limit    = {1'b0, max_name_length} + pcu8_pkg::CountWidth'(1);
    cp_shift = {code_point[pcu8_pkg::CpWidth-7:0], s1_byte[5:0] & pcu8_pkg::ContBits[5:0]};

    if (s1_has) begin
      if (byte_count < limit) begin
        byte_count_next = byte_count + pcu8_pkg::CountWidth'(1);
      end
      if (s1_byte == pcu8_pkg::DotByte && dot_prefix == pcu8_pkg::DOT_NONE) begin
        dot_prefix_next = pcu8_pkg::DOT_ONE;
      end else if (s1_byte == pcu8_pkg::DotByte && dot_prefix == pcu8_pkg::DOT_ONE) begin
        dot_prefix_next = pcu8_pkg::DOT_TWO;
      end else begin
        dot_prefix_next = pcu8_pkg::DOT_OTHER;
      end
      if (s1_byte < pcu8_pkg::SpaceByte || s1_byte == pcu8_pkg::DelByte ||
          s1_byte == pcu8_pkg::SlashByte || s1_byte == pcu8_pkg::BslashByte) begin
        forbidden_next = 1'b1;
      end
      if (!enc_error) begin
        if (pending == 2'd0) begin
          if (s1_byte > pcu8_pkg::DelByte) begin
            if ((s1_byte & 8'he0) == pcu8_pkg::ContMask) begin
              pending_next    = 2'd1;
              code_point_next = pcu8_pkg::CpWidth'(s1_byte[4:0]);
              seq_min_next    = pcu8_pkg::MinTwo;
            end else if ((s1_byte & 8'hf0) == 8'he0) begin
              pending_next    = 2'd2;
              code_point_next = pcu8_pkg::CpWidth'(s1_byte[3:0]);
              seq_min_next    = pcu8_pkg::MinThree;
            end else if ((s1_byte & 8'hf8) == 8'hf0) begin
              pending_next    = 2'd3;
              code_point_next = pcu8_pkg::CpWidth'(s1_byte[2:0]);
              seq_min_next    = pcu8_pkg::MinFour;
            end else begin
              enc_error_next = 1'b1;
            end
          end
        end else if ((s1_byte & pcu8_pkg::ContMask) != pcu8_pkg::ContTag) begin
          enc_error_next = 1'b1;
          pending_next   = 2'd0;
        end else begin
          code_point_next = cp_shift;
          pending_next    = pending - 2'd1;
          if (pending == 2'd1) begin
            if (cp_shift < pcu8_pkg::CpWidth'(seq_min) ||
                cp_shift > pcu8_pkg::MaxCodePoint ||
                (cp_shift >= pcu8_pkg::SurrogateLow &&
                 cp_shift <= pcu8_pkg::SurrogateHigh)) begin
              enc_error_next = 1'b1;
            end
          end
        end
      end
    end

    if (s1_last) begin
      if (pending_next != 2'd0) begin
        enc_error_next = 1'b1;
      end
      if (byte_count_next == '0 ||
          byte_count_next > {1'b0, max_name_length}) begin
        reason_next = pcu8_pkg::REASON_LENGTH;
      end else if (dot_prefix_next == pcu8_pkg::DOT_ONE ||
                   dot_prefix_next == pcu8_pkg::DOT_TWO) begin
        reason_next = pcu8_pkg::REASON_DOT;
      end else if (forbidden_next) begin
        reason_next = pcu8_pkg::REASON_FORBIDDEN;
      end else if (enc_error_next) begin
        reason_next = pcu8_pkg::REASON_UTF8;
      end else begin
        reason_next = pcu8_pkg::REASON_OK;
      end
      byte_count_next = '0;
      pending_next    = 2'd0;
      code_point_next = '0;
      seq_min_next    = '0;
      dot_prefix_next = pcu8_pkg::DOT_NONE;
      forbidden_next  = 1'b0;
      enc_error_next  = 1'b0;
    end
  end

  // component state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      pending        <= 2'd0;
      code_point     <= '0;
      seq_min        <= '0;
      dot_prefix     <= pcu8_pkg::DOT_NONE;
      forbidden_seen <= 1'b0;
      enc_error      <= 1'b0;
    end else if (s1_fire) begin
      byte_count     <= byte_count_next;
      pending        <= pending_next;
      code_point     <= code_point_next;
      seq_min        <= seq_min_next;
      dot_prefix     <= dot_prefix_next;
      forbidden_seen <= forbidden_next;
      enc_error      <= enc_error_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      reason <= reason_next;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  a_clear_after_verdict: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_last) |=> (byte_count == '0 && pending == 2'd0 && !enc_error))
    else $error("component state not cleared after verdict");

  a_pending_no_error: assert property (@(posedge clk) disable iff (rst)
    (pending != 2'd0) |-> !enc_error)
    else $error("continuations pending after encoding error");

  a_ok_matches_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (name_ok == (fail_reason == pcu8_pkg::REASON_OK)))
    else $error("name_ok disagrees with fail_reason");

endmodule
